[hw/rtl/ccx_pkg.sv]
package ccx_pkg;

    localparam int unsigned SAMPLE_W      = 32;
    localparam int unsigned EXT_W         = 64;
    localparam int unsigned SECS_W        = 45;
    localparam int unsigned PART_W        = 10;
    localparam int unsigned MHZ_W         = 10;
    localparam int unsigned REM_W         = 20;
    localparam int unsigned CNT_W         = 6;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam logic [MHZ_W-1:0] CLOCK_MHZ_RESET = MHZ_W'(550);
    localparam logic [REM_W-1:0] MEG             = REM_W'(1000000);
    localparam logic [REM_W-1:0] THOUSAND        = REM_W'(1000);

    // floor(x / 1000) = (x * RECIP_M) >> RECIP_K for x below one million
    localparam int unsigned RECIP_K = 30;
    localparam int unsigned PROD_W  = 41;
    localparam logic [PROD_W-1:0] RECIP_M = PROD_W'(1073742);

    // long division by one million in 12-bit digits
    // floor(x / 1000000) = ((x >> 6) * SEC_RECIP_M) >> SEC_RECIP_K for x below 2^32
    localparam int unsigned DIGIT_W     = 12;
    localparam int unsigned SEC_DIGITS  = 5;
    localparam int unsigned SEC_X_W     = REM_W + DIGIT_W;
    localparam int unsigned SEC_SHIFT   = 6;
    localparam int unsigned SEC_RECIP_K = 40;
    localparam int unsigned SEC_PROD_W  = 53;
    localparam logic [SEC_PROD_W-1:0] SEC_RECIP_M = SEC_PROD_W'(70368745);

    typedef struct packed {
        logic [SAMPLE_W-1:0] elapsed_cycles;
        logic [EXT_W-1:0]    extended_cycles;
    } ccx_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MHZ,
        ST_SEC_MUL,
        ST_SEC_SUB,
        ST_MUL,
        ST_SUB,
        ST_DONE
    } back_state_t;

endpackage

[hw/rtl/ccx_front.sv]
module ccx_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ccx_pkg::SAMPLE_W-1:0]  s_counter_sample,
    input  logic [ccx_pkg::SAMPLE_W-1:0]  s_reference_count,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ccx_pkg::ccx_item_t            push_item
);
    import ccx_pkg::*;

    logic [SAMPLE_W-1:0] wrap_reg, wrap_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                take;
    logic [SAMPLE_W-1:0] wrap_upd;

    assign s_ready    = push_ready;
    assign take       = s_valid && push_ready;
    assign push_valid = take;

    // a sample below the previous one means the counter rolled over
    assign wrap_upd = (s_counter_sample < prev_reg) ? wrap_reg + SAMPLE_W'(1) : wrap_reg;

    always_comb begin
        wrap_next = wrap_reg;
        prev_next = prev_reg;
        if (take) begin
            wrap_next = wrap_upd;
            prev_next = s_counter_sample;
        end
    end

    assign push_item.elapsed_cycles  = s_counter_sample - s_reference_count;
    assign push_item.extended_cycles = {wrap_upd, s_counter_sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= '0;
            prev_reg <= '0;
        end else begin
            wrap_reg <= wrap_next;
            prev_reg <= prev_next;
        end
    end

endmodule

[hw/rtl/ccx_queue.sv]
module ccx_queue #(
    parameter int unsigned DEPTH = ccx_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  ccx_pkg::ccx_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ccx_pkg::ccx_item_t pop_item
);
    import ccx_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ccx_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

[hw/rtl/ccx_back.sv]
module ccx_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ccx_pkg::MHZ_W-1:0]    clock_mhz,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  ccx_pkg::ccx_item_t           pop_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ccx_pkg::SAMPLE_W-1:0] m_elapsed_cycles,
    output logic [ccx_pkg::EXT_W-1:0]    m_extended_cycles,
    output logic [ccx_pkg::SECS_W-1:0]   m_whole_seconds,
    output logic [ccx_pkg::PART_W-1:0]   m_millis_part,
    output logic [ccx_pkg::PART_W-1:0]   m_micros_part,
    output logic [ccx_pkg::EXT_W-1:0]    m_total_micros
);
    import ccx_pkg::*;

    localparam int unsigned TOP_W = EXT_W - SEC_DIGITS * DIGIT_W;

    back_state_t         state_reg, state_next;
    logic [EXT_W-1:0]    work_reg, work_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] elapsed_reg, elapsed_next;
    logic [EXT_W-1:0]    ext_reg, ext_next;
    logic [EXT_W-1:0]    total_reg, total_next;
    logic [SECS_W-1:0]   secs_reg, secs_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SEC_PROD_W-1:0] sec_prod_reg, sec_prod_next;
    logic [PART_W-1:0]   ms_reg, ms_next;
    logic [PART_W-1:0]   us_reg, us_next;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_elapsed_reg, out_elapsed_next;
    logic [EXT_W-1:0]    out_ext_reg, out_ext_next;
    logic [SECS_W-1:0]   out_secs_reg, out_secs_next;
    logic [PART_W-1:0]   out_ms_reg, out_ms_next;
    logic [PART_W-1:0]   out_us_reg, out_us_next;
    logic [EXT_W-1:0]    out_total_reg, out_total_next;

    logic [MHZ_W-1:0]    mhz_eff;
    logic [REM_W-1:0]    divisor;
    logic [REM_W:0]      trial;
    logic [REM_W:0]      diff;
    logic                ge;
    logic [REM_W-1:0]    rem_step;
    logic [EXT_W-1:0]    work_step;
    logic [SEC_X_W-1:0]  sec_x;
    logic [DIGIT_W-1:0]  sec_q;
    logic [SEC_X_W-1:0]  sec_rem_wide;
    logic [EXT_W-1:0]    sec_work;
    logic [PART_W-1:0]   ms_val;
    logic [REM_W-1:0]    us_wide;

    // zero clock is treated as 1 MHz
    assign mhz_eff = (clock_mhz == '0) ? MHZ_W'(1) : clock_mhz;

    // restoring divider by the clock in mhz, one quotient bit per cycle
    assign divisor   = REM_W'(mhz_eff);
    assign trial     = {rem_reg, work_reg[EXT_W-1]};
    assign ge        = (trial >= {1'b0, divisor});
    assign diff      = trial - {1'b0, divisor};
    assign rem_step  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    assign work_step = {work_reg[EXT_W-2:0], ge};

    // one digit of the division by one million per pass through the multiply and subtract states
    assign sec_x        = {rem_reg, work_reg[EXT_W-1 -: DIGIT_W]};
    assign sec_q        = sec_prod_reg[SEC_RECIP_K+DIGIT_W-1:SEC_RECIP_K];
    assign sec_rem_wide = sec_x - SEC_X_W'(sec_q) * SEC_X_W'(MEG);
    assign sec_work     = {work_reg[EXT_W-DIGIT_W-1:0], sec_q};

    assign ms_val  = prod_reg[RECIP_K+PART_W-1:RECIP_K];
    assign us_wide = rem_reg - REM_W'(ms_val) * THOUSAND;

    assign pop_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        work_next        = work_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        elapsed_next     = elapsed_reg;
        ext_next         = ext_reg;
        total_next       = total_reg;
        secs_next        = secs_reg;
        prod_next        = prod_reg;
        sec_prod_next    = sec_prod_reg;
        ms_next          = ms_reg;
        us_next          = us_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_elapsed_next = out_elapsed_reg;
        out_ext_next     = out_ext_reg;
        out_secs_next    = out_secs_reg;
        out_ms_next      = out_ms_reg;
        out_us_next      = out_us_reg;
        out_total_next   = out_total_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    elapsed_next = pop_item.elapsed_cycles;
                    ext_next     = pop_item.extended_cycles;
                    work_next    = pop_item.extended_cycles;
                    rem_next     = '0;
                    cnt_next     = CNT_W'(EXT_W - 1);
                    state_next   = ST_DIV_MHZ;
                end
            end
            ST_DIV_MHZ: begin
                work_next = work_step;
                rem_next  = rem_step;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    // total micros done; its top bits seed the remainder of the next divide
                    total_next = work_step;
                    work_next  = {work_step[EXT_W-TOP_W-1:0], TOP_W'(0)};
                    rem_next   = REM_W'(work_step[EXT_W-1:EXT_W-TOP_W]);
                    cnt_next   = CNT_W'(SEC_DIGITS - 1);
                    state_next = ST_SEC_MUL;
                end
            end
            ST_SEC_MUL: begin
                sec_prod_next = SEC_PROD_W'(sec_x[SEC_X_W-1:SEC_SHIFT]) * SEC_RECIP_M;
                state_next    = ST_SEC_SUB;
            end
            ST_SEC_SUB: begin
                work_next = sec_work;
                rem_next  = sec_rem_wide[REM_W-1:0];
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    secs_next  = sec_work[SECS_W-1:0];
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SEC_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(rem_reg) * RECIP_M;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                ms_next    = ms_val;
                us_next    = us_wide[PART_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next   = 1'b1;
                    out_elapsed_next = elapsed_reg;
                    out_ext_next     = ext_reg;
                    out_secs_next    = secs_reg;
                    out_ms_next      = ms_reg;
                    out_us_next      = us_reg;
                    out_total_next   = total_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg        <= work_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        elapsed_reg     <= elapsed_next;
        ext_reg         <= ext_next;
        total_reg       <= total_next;
        secs_reg        <= secs_next;
        prod_reg        <= prod_next;
        sec_prod_reg    <= sec_prod_next;
        ms_reg          <= ms_next;
        us_reg          <= us_next;
        out_elapsed_reg <= out_elapsed_next;
        out_ext_reg     <= out_ext_next;
        out_secs_reg    <= out_secs_next;
        out_ms_reg      <= out_ms_next;
        out_us_reg      <= out_us_next;
        out_total_reg   <= out_total_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_elapsed_cycles  = out_elapsed_reg;
    assign m_extended_cycles = out_ext_reg;
    assign m_whole_seconds   = out_secs_reg;
    assign m_millis_part     = out_ms_reg;
    assign m_micros_part     = out_us_reg;
    assign m_total_micros    = out_total_reg;

    a_rem_below_mhz: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_MHZ) |-> (rem_reg < REM_W'(mhz_eff)))
        else $error("partial remainder not below clock divisor");

    a_rem_below_meg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEC_MUL) |-> (rem_reg < MEG))
        else $error("partial remainder not below one million");

    a_parts_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_ms_reg < PART_W'(1000)) && (out_us_reg < PART_W'(1000)))
        else $error("millis or micros part out of range");

    a_total_split: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_total_reg == EXT_W'(out_secs_reg) * EXT_W'(MEG)
                          + EXT_W'(out_ms_reg) * EXT_W'(THOUSAND) + EXT_W'(out_us_reg)))
        else $error("time split does not add up to total micros");

endmodule

[hw/rtl/cycle_counter_extend_and_split.sv]
// the back takes no new transaction until the last one has gone into its output register
// the back runs 64 bit-serial divide steps by the clock in MHz, then reciprocal long
//   division by one million
// a two-entry queue lets the front take the next transaction while the back computes
// reset: synchronous active low; clears wrap count, previous sample, queue and control,
//   and loads clock_mhz with 550
module cycle_counter_extend_and_split #(
    parameter int unsigned QUEUE_DEPTH = ccx_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ccx_pkg::MHZ_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ccx_pkg::SAMPLE_W-1:0] s_counter_sample,
    input  logic [ccx_pkg::SAMPLE_W-1:0] s_reference_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ccx_pkg::SAMPLE_W-1:0] m_elapsed_cycles,
    output logic [ccx_pkg::EXT_W-1:0]    m_extended_cycles,
    output logic [ccx_pkg::SECS_W-1:0]   m_whole_seconds,
    output logic [ccx_pkg::PART_W-1:0]   m_millis_part,
    output logic [ccx_pkg::PART_W-1:0]   m_micros_part,
    output logic [ccx_pkg::EXT_W-1:0]    m_total_micros
);
    import ccx_pkg::*;

    logic [MHZ_W-1:0] clock_mhz_reg, clock_mhz_next;
    logic             push_valid, push_ready;
    ccx_item_t        push_item;
    logic             pop_valid, pop_ready;
    ccx_item_t        pop_item;

    assign clock_mhz_next = cfg_wr_en ? cfg_wr_data : clock_mhz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_mhz_reg <= CLOCK_MHZ_RESET;
        end else begin
            clock_mhz_reg <= clock_mhz_next;
        end
    end

    ccx_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_counter_sample  (s_counter_sample),
        .s_reference_count (s_reference_count),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_item         (push_item)
    );

    ccx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ccx_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .clock_mhz         (clock_mhz_reg),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_item          (pop_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_elapsed_cycles  (m_elapsed_cycles),
        .m_extended_cycles (m_extended_cycles),
        .m_whole_seconds   (m_whole_seconds),
        .m_millis_part     (m_millis_part),
        .m_micros_part     (m_micros_part),
        .m_total_micros    (m_total_micros)
    );

endmodule

[tb/tb_cycle_counter_extend_and_split.sv]
module tb_cycle_counter_extend_and_split;
    import ccx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_PER_PHASE = 90;

    typedef struct {
        logic [SAMPLE_W-1:0] elapsed;
        logic [EXT_W-1:0]    extended;
        logic [SECS_W-1:0]   seconds;
        logic [PART_W-1:0]   millis;
        logic [PART_W-1:0]   micros;
        logic [EXT_W-1:0]    total_us;
    } timestamp_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [MHZ_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_counter_sample;
    logic [SAMPLE_W-1:0] s_reference_count;
    logic                m_valid;
    logic                m_ready;
    logic [SAMPLE_W-1:0] m_elapsed_cycles;
    logic [EXT_W-1:0]    m_extended_cycles;
    logic [SECS_W-1:0]   m_whole_seconds;
    logic [PART_W-1:0]   m_millis_part;
    logic [PART_W-1:0]   m_micros_part;
    logic [EXT_W-1:0]    m_total_micros;

    timestamp_t          pending_timestamps[$];
    logic [SAMPLE_W-1:0] model_wraps;
    logic [SAMPLE_W-1:0] model_prev_sample;
    logic [MHZ_W-1:0]    model_clock_mhz;
    int unsigned         send_idle_pct;
    int unsigned         sink_stall_pct;
    int unsigned         mismatch_count;
    int unsigned         cycle_count;

    cycle_counter_extend_and_split i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_counter_sample  (s_counter_sample),
        .s_reference_count (s_reference_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_elapsed_cycles  (m_elapsed_cycles),
        .m_extended_cycles (m_extended_cycles),
        .m_whole_seconds   (m_whole_seconds),
        .m_millis_part     (m_millis_part),
        .m_micros_part     (m_micros_part),
        .m_total_micros    (m_total_micros)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cycle_counter_extend_and_split regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // wrap counting, 64-bit extension and time split at the current clock setting
    function automatic timestamp_t split_timestamp(logic [SAMPLE_W-1:0] now_count,
                                                   logic [SAMPLE_W-1:0] ref_count);
        timestamp_t ts;
        logic [EXT_W-1:0] mhz;
        logic [EXT_W-1:0] hz;
        logic [EXT_W-1:0] per_ms;
        logic [EXT_W-1:0] secs;
        logic [EXT_W-1:0] rem;
        logic [EXT_W-1:0] ms;
        logic [EXT_W-1:0] rem2;
        logic [EXT_W-1:0] us;
        if (now_count < model_prev_sample) begin
            model_wraps = model_wraps + 1;
        end
        model_prev_sample = now_count;
        mhz = (model_clock_mhz == '0) ? 64'd1 : 64'(model_clock_mhz);
        hz = mhz * 64'd1000000;
        per_ms = mhz * 64'd1000;
        ts.extended = {model_wraps, now_count};
        secs = ts.extended / hz;
        rem = ts.extended - secs * hz;
        ms = rem / per_ms;
        rem2 = rem - ms * per_ms;
        us = rem2 / mhz;
        ts.elapsed = now_count - ref_count;
        ts.seconds = secs[SECS_W-1:0];
        ts.millis = ms[PART_W-1:0];
        ts.micros = us[PART_W-1:0];
        ts.total_us = secs * 64'd1000000 + ms * 64'd1000 + us;
        return ts;
    endfunction

    task automatic report_mismatch(string what, logic [EXT_W-1:0] got, logic [EXT_W-1:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        timestamp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_timestamps.size() == 0) begin
                report_mismatch("transaction with none expected, extended_cycles",
                                m_extended_cycles, '0);
            end else begin
                want = pending_timestamps.pop_front();
                if (m_elapsed_cycles !== want.elapsed)
                    report_mismatch("elapsed_cycles", EXT_W'(m_elapsed_cycles),
                                    EXT_W'(want.elapsed));
                if (m_extended_cycles !== want.extended)
                    report_mismatch("extended_cycles", m_extended_cycles, want.extended);
                if (m_whole_seconds !== want.seconds)
                    report_mismatch("whole_seconds", EXT_W'(m_whole_seconds),
                                    EXT_W'(want.seconds));
                if (m_millis_part !== want.millis)
                    report_mismatch("millis_part", EXT_W'(m_millis_part),
                                    EXT_W'(want.millis));
                if (m_micros_part !== want.micros)
                    report_mismatch("micros_part", EXT_W'(m_micros_part),
                                    EXT_W'(want.micros));
                if (m_total_micros !== want.total_us)
                    report_mismatch("total_micros", m_total_micros, want.total_us);
            end
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] now_count, logic [SAMPLE_W-1:0] ref_count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_counter_sample <= now_count;
        s_reference_count <= ref_count;
        do @(posedge aclk); while (!s_ready);
        pending_timestamps.push_back(split_timestamp(now_count, ref_count));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_timestamps.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_clock_mhz(logic [MHZ_W-1:0] mhz);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mhz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_clock_mhz = mhz;
        @(posedge aclk);
    endtask

    // equal samples, full-scale fields, wraps and references ahead of the sample
    task automatic test_directed_samples();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000, 32'h0000_0001);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA);
        send_sample(32'hAAAA_AAAA, 32'h5555_5555);
        send_sample(32'h1234_5678, 32'hFFFF_FFFF);
    endtask

    // low and high clock, zero clock and values above the nominal range
    task automatic test_clock_settings();
        logic [MHZ_W-1:0] settings[5];
        settings = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd1001};
        foreach (settings[i]) begin
            set_clock_mhz(settings[i]);
            send_sample(32'hFFFF_FFFF, $urandom);
            send_sample(32'h0000_0000, $urandom);
            send_sample($urandom, $urandom);
        end
    endtask

    // mostly a running counter with random steps, some unrelated samples as noise
    task automatic test_random_traffic();
        logic [SAMPLE_W-1:0] now_count;
        logic [SAMPLE_W-1:0] ref_count;
        int unsigned idle_pct[4];
        int unsigned stall_pct[4];
        logic [MHZ_W-1:0] mhz[4];
        idle_pct = '{0, 87, 0, 30};
        stall_pct = '{0, 0, 87, 30};
        mhz = '{10'd550, 10'd1, 10'd1000, 10'($urandom_range(1023, 1))};
        now_count = model_prev_sample;
        for (int p = 0; p < 4; p++) begin
            set_clock_mhz(mhz[p]);
            send_idle_pct = idle_pct[p];
            sink_stall_pct = stall_pct[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0: now_count = now_count;
                    1, 2: now_count = $urandom;
                    3, 4, 5: now_count = now_count + $urandom_range(100000);
                    default: now_count = now_count + $urandom;
                endcase
                if ($urandom_range(3) == 0) begin
                    ref_count = $urandom;
                end else begin
                    ref_count = now_count - $urandom_range(1000000);
                end
                send_sample(now_count, ref_count);
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_counter_sample = '0;
        s_reference_count = '0;
        m_ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        model_wraps = '0;
        model_prev_sample = '0;
        model_clock_mhz = CLOCK_MHZ_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_samples();
        test_clock_settings();
        test_random_traffic();

        drain_results();
        repeat (150) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("cycle_counter_extend_and_split regression: pass");
        end else begin
            $display("cycle_counter_extend_and_split regression: fail");
        end
        $finish;
    end

endmodule
